[hdl/xee_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xee_pkg
// Shared types, constants and character lookup for the XML escape encoder.
// ----------------------------------------------------------------------------
package xee_pkg;

  localparam int unsigned CharW = 16;
  localparam int unsigned IdxW  = 3;   // position inside a run of up to six

  // Register indexes on the configuration port
  localparam logic CFG_WIDE_HIGH = 1'b0;
  localparam logic CFG_HEX_UPPER = 1'b1;

  // Escape range limits
  localparam logic [CharW-1:0] CTRL_LIMIT = 16'h0020;
  localparam logic [CharW-1:0] PRINT_MAX  = 16'h007E;
  localparam logic [CharW-1:0] HIGH_LIMIT = 16'h00A0;

  localparam logic [CharW-1:0] CH_AMP  = 16'h0026;
  localparam logic [CharW-1:0] CH_LT   = 16'h003C;
  localparam logic [CharW-1:0] CH_GT   = 16'h003E;
  localparam logic [CharW-1:0] CH_QUOT = 16'h0022;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_HEX,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT
  } kind_e;

  // Index of the final character of a run
  function automatic logic [IdxW-1:0] last_idx(input kind_e kind);
    logic [IdxW-1:0] r;
    unique case (kind)
      KIND_HEX:           r = 3'd5;
      KIND_AMP:           r = 3'd4;
      KIND_LT, KIND_GT:   r = 3'd3;
      KIND_QUOT:          r = 3'd5;
      default:            r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else if (upper) begin
      r = 8'h37 + {4'h0, nib};
    end else begin
      r = 8'h57 + {4'h0, nib};
    end
    return r;
  endfunction

  // Character at position idx of the run for one input
  function automatic logic [CharW-1:0] run_char(input kind_e kind,
                                                input logic [CharW-1:0] code,
                                                input logic [IdxW-1:0] idx,
                                                input logic upper);
    logic [7:0] ch;
    ch = 8'h3B;  // ';' closes every entity
    unique case (kind)
      KIND_HEX: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h23;
          3'd2:    ch = 8'h78;
          3'd3:    ch = hex_digit(code[7:4], upper);
          3'd4:    ch = hex_digit(code[3:0], upper);
          default: ch = 8'h3B;
        endcase
      end
      KIND_AMP: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6D;
          3'd3:    ch = 8'h70;
          default: ch = 8'h3B;
        endcase
      end
      KIND_LT: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h6C;
          3'd2:    ch = 8'h74;
          default: ch = 8'h3B;
        endcase
      end
      KIND_GT: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h67;
          3'd2:    ch = 8'h74;
          default: ch = 8'h3B;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd0:    ch = 8'h26;
          3'd1:    ch = 8'h71;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h6F;
          3'd4:    ch = 8'h74;
          default: ch = 8'h3B;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return (kind == KIND_PLAIN) ? code : {8'h00, ch};
  endfunction

endpackage

[hdl/xml_entity_escape_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_escape_encoder_top
// Escapes a stream of character code units into XML-safe character runs.
// ----------------------------------------------------------------------------
// channel   dir  tdata            tuser     tlast
// s_axis    in   code_unit[15:0]  -         string_end
// m_axis    out  out_char[15:0]   run_last  string_done
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// An accepted unit is classified into a run register; the output register
// then takes one character per cycle from it while the output is not stalled.
// Plain characters stream at one per cycle; an escaped unit's run of 4 to 6
// characters is drained by the single output register before the next unit.
// Reset clears both valid flags and loads the register defaults.
// A stalled output holds the run and back-pressures the input.
// ----------------------------------------------------------------------------
module xml_entity_escape_encoder_top
  import xee_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [CharW-1:0] s_axis_tdata,   // [15:0] code_unit
  input  logic             s_axis_tlast,   // string_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,   // [15:0] out_char
  output logic             m_axis_tuser,   // [0] run_last
  output logic             m_axis_tlast,   // string_done
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic             cfg_data_i
);

  logic wide_q, upper_q;

  logic             run_valid_q;
  kind_e            kind_q;
  logic [CharW-1:0] code_q;
  logic             done_q;
  logic [IdxW-1:0]  idx_q;

  logic             m_valid_q, m_user_q, m_last_q;
  logic [CharW-1:0] m_data_q;

  logic             out_free, at_last, s_acc, emit, esc;
  logic [CharW-1:0] code_in;
  kind_e            kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= 1'b0;
      upper_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDE_HIGH: wide_q  <= cfg_data_i;
        CFG_HEX_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the incoming unit
  always_comb begin
    code_in = wide_q ? {8'h00, s_axis_tdata[7:0]} : s_axis_tdata;
    esc = (code_in < CTRL_LIMIT) ||
          (code_in > PRINT_MAX && (wide_q || code_in < HIGH_LIMIT));
    if (esc) begin
      kind_d = KIND_HEX;
    end else if (code_in == CH_AMP) begin
      kind_d = KIND_AMP;
    end else if (code_in == CH_LT) begin
      kind_d = KIND_LT;
    end else if (code_in == CH_GT) begin
      kind_d = KIND_GT;
    end else if (code_in == CH_QUOT) begin
      kind_d = KIND_QUOT;
    end else begin
      kind_d = KIND_PLAIN;
    end
  end

  assign out_free      = !m_valid_q || m_axis_tready;
  assign at_last       = (idx_q == last_idx(kind_q));
  assign emit          = run_valid_q && out_free;
  assign s_axis_tready = !run_valid_q || (out_free && at_last);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (s_acc) begin
      run_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (emit) begin
      if (at_last) begin
        run_valid_q <= 1'b0;
      end
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= kind_d;
      code_q <= code_in;
      done_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= run_char(kind_q, code_q, idx_q, upper_q);
      m_user_q <= at_last;
      m_last_q <= at_last && done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

[hdl/xee_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xee_checker
// Port-level checks on the escaped output stream.
// ----------------------------------------------------------------------------
module xee_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled transfer holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // End of string only on the end of a run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("string_done without run_last");

  // Characters inside an escape run are ASCII
  a_inner_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] == 8'h00)
    else $error("non-ASCII character inside a run");

  // Markup characters never leave unescaped
  a_no_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != 16'h003C && m_axis_tdata != 16'h003E &&
      m_axis_tdata != 16'h0022 && !(m_axis_tdata == 16'h0026 && m_axis_tuser))
    else $error("raw markup character on output");

endmodule

bind xml_entity_escape_encoder_top xee_checker u_xee_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
